// ===== design/swp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// swp_pkg
// Shared types and constants of the stepper waypoint sequencer.
// ----------------------------------------------------------------------------
package swp_pkg;

	localparam int WAYPOINTS = 16;
	localparam int WP_AW     = $clog2(WAYPOINTS);

	localparam logic [14:0] DWELL_RATE  = 15'd1000;
	localparam logic [14:0] TRAVEL_RST  = 15'd1000;

	typedef enum logic [2:0] {
		CMD_WRITE  = 3'd0,
		CMD_START  = 3'd1,
		CMD_TICK   = 3'd2,
		CMD_PAUSE  = 3'd3,
		CMD_RESUME = 3'd4,
		CMD_STOP   = 3'd5,
		CMD_SKIP   = 3'd6,
		CMD_ZERO   = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		RS_STOPPED = 2'd0,
		RS_RUN     = 2'd1,
		RS_PAUSED  = 2'd2,
		RS_DWELL   = 2'd3
	} run_state_t;

	typedef struct packed {
		logic [2:0]         command;
		logic [3:0]         waypoint_index;
		logic signed [31:0] target_position;
		logic [14:0]        target_rate;
		logic [15:0]        dwell_ticks;
		logic               waypoint_enable;
	} in_item_t;

	typedef struct packed {
		logic               step_pulse;
		logic               step_direction;
		logic [14:0]        step_rate;
		logic signed [31:0] current_position;
		logic [1:0]         run_state;
		logic [3:0]         active_waypoint;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] pos;
		logic [14:0]        rate;
		logic [15:0]        dwell;
	} wp_entry_t;

endpackage

// ===== design/stepper_waypoint_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_waypoint_sequencer
// Waypoint table in a synchronous RAM; per-command sequencer with a scan
// counter over the enable bits and a radix-2 divider for the ramp increment.
// ----------------------------------------------------------------------------
// channel   dir  handshake               payload
// in        in   in_valid / in_stall     in_data  (in_item_t)
// out       out  out_valid / out_stall   out_data (out_item_t)
// cfg       in   cfg_we                  cfg_wdata (travel_rate)
//
// Write, pause, resume, stop, skip, zero and idle ticks go straight to the result.
// A step tick reads the table and checks the distance; each reached waypoint
// adds a scan over the enable bits, the table reads and the distance check,
// and the increment divider when it runs.
// Start adds a scan, the waypoint 0 write, the table reads and the divider.
// Reset clears flags, valid bits and enables; table entries read as zero.
// A result waiting on out_stall does not block acceptance of the next
// transaction; that one completes once the output register frees.
// ----------------------------------------------------------------------------
module stepper_waypoint_sequencer
	import swp_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_data,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_data,
	input  logic      cfg_we,
	input  logic [14:0] cfg_wdata
);

	typedef enum logic [3:0] {
		S_IDLE, S_SCAN, S_SRD, S_SWR, S_ACT_RD0, S_ACT_RD1, S_ACT_CALC,
		S_DIV, S_STEP_RD, S_STEP_CHK, S_DONE
	} state_t;

	state_t             st_q;
	logic [14:0]        travel_q;
	logic signed [31:0] pos_q;
	logic [WP_AW-1:0]   active_q;
	logic [WP_AW-1:0]   act_q;
	logic [WP_AW-1:0]   found_q;
	logic [WP_AW:0]     scan_q;
	logic [15:0]        dwell_q;
	logic [15:0]        inc_q;
	logic [14:0]        rate_q;
	logic               run_q;
	logic               pause_q;
	logic               org_q;
	logic               pulse_q;
	logic               dir_q;
	logic [WAYPOINTS-1:0] en_q;
	logic [WAYPOINTS-1:0] vld_q;
	wp_entry_t          act_ent_q;
	logic [14:0]        num_q;
	logic [14:0]        den_q;
	logic [15:0]        rem_q;
	logic [3:0]         cnt_q;
	logic               out_valid_q;
	out_item_t          out_data_q;

	wp_entry_t          mem [WAYPOINTS];
	wp_entry_t          rd_q;
	logic               rd_ok_q;
	logic [WP_AW-1:0]   rd_addr;
	logic               mem_we;
	logic [WP_AW-1:0]   mem_wa;
	wp_entry_t          mem_wd;

	wp_entry_t          ent;
	logic signed [31:0] dpos;
	logic signed [32:0] d33;
	logic [32:0]        ad;
	logic [14:0]        prev_rate;
	logic signed [15:0] f16;
	logic [14:0]        af;
	logic [15:0]        trial;
	logic               qbit;
	logic [14:0]        ramp_rate;
	logic [14:0]        rdiff;
	logic               out_free;
	logic               accept;
	logic [15:0]        dwell_dec;
	logic [1:0]         rs;

	assign accept   = in_valid && !in_stall;
	assign in_stall = (st_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;

	always_comb begin
		unique case (st_q)
			S_SRD:     rd_addr = found_q;
			S_ACT_RD0: rd_addr = act_q;
			S_ACT_RD1: rd_addr = act_q - 1'b1;
			default:   rd_addr = active_q;
		endcase
	end

	always_comb begin
		mem_we = 1'b0;
		mem_wa = WP_AW'(in_data.waypoint_index);
		mem_wd = '{pos: in_data.target_position, rate: in_data.target_rate,
			dwell: in_data.dwell_ticks};
		if (st_q == S_IDLE) begin
			mem_we = accept && (in_data.command == CMD_WRITE)
				&& (int'(in_data.waypoint_index) < WAYPOINTS);
		end else if (st_q == S_SWR) begin
			mem_we = 1'b1;
			mem_wa = '0;
			mem_wd = '{pos: ent.pos, rate: travel_q, dwell: 16'd0};
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		rd_q <= mem[rd_addr];
	end

	assign ent       = rd_ok_q ? rd_q : '0;
	assign dpos      = (st_q == S_ACT_CALC) ? act_ent_q.pos : ent.pos;
	assign d33       = {dpos[31], dpos} - {pos_q[31], pos_q};
	assign ad        = d33[32] ? 33'(-d33) : 33'(d33);
	assign prev_rate = (act_q == '0) ? 15'd1 : ent.rate;
	assign f16       = signed'({1'b0, act_ent_q.rate}) - signed'({1'b0, prev_rate});
	assign af        = f16[15] ? 15'(-f16) : f16[14:0];
	assign trial     = {rem_q[14:0], num_q[14]};
	assign qbit      = (trial >= {1'b0, den_q});
	assign dwell_dec = dwell_q - 16'd1;

	always_comb begin
		ramp_rate = rate_q;
		rdiff     = '0;
		if (rate_q < ent.rate) begin
			rdiff     = ent.rate - rate_q;
			ramp_rate = ({1'b0, rdiff} > inc_q) ? 15'(rate_q + inc_q) : ent.rate;
		end else if (rate_q > ent.rate) begin
			rdiff     = rate_q - ent.rate;
			ramp_rate = ({1'b0, rdiff} > inc_q) ? 15'(rate_q - inc_q) : ent.rate;
		end
	end

	always_comb begin
		if (!run_q)           rs = RS_STOPPED;
		else if (pause_q)     rs = RS_PAUSED;
		else if (dwell_q != 0) rs = RS_DWELL;
		else                  rs = RS_RUN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			travel_q    <= TRAVEL_RST;
			pos_q       <= '0;
			active_q    <= '0;
			act_q       <= '0;
			found_q     <= '0;
			scan_q      <= '0;
			dwell_q     <= '0;
			inc_q       <= '0;
			rate_q      <= '0;
			run_q       <= 1'b0;
			pause_q     <= 1'b0;
			org_q       <= 1'b0;
			pulse_q     <= 1'b0;
			dir_q       <= 1'b0;
			en_q        <= '0;
			vld_q       <= '0;
			rd_ok_q     <= 1'b0;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			rd_ok_q <= vld_q[rd_addr];
			if (mem_we) begin
				vld_q[mem_wa] <= 1'b1;
			end
			if (cfg_we) begin
				travel_q <= cfg_wdata;
			end
			if (st_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						pulse_q <= 1'b0;
						dir_q   <= 1'b0;
						unique case (cmd_t'(in_data.command))
							CMD_WRITE: begin
								if (mem_we) begin
									en_q[mem_wa] <= in_data.waypoint_enable;
								end
								st_q <= S_DONE;
							end
							CMD_START: begin
								active_q <= '0;
								org_q    <= 1'b0;
								scan_q   <= (WP_AW+1)'(1);
								st_q     <= S_SCAN;
							end
							CMD_TICK: begin
								if (run_q && !pause_q && dwell_q == 0) begin
									st_q <= S_STEP_RD;
								end else begin
									if (run_q && !pause_q) begin
										dwell_q <= dwell_dec;
										rate_q  <= (dwell_dec != 0) ? DWELL_RATE : 15'd1;
									end
									st_q <= S_DONE;
								end
							end
							CMD_PAUSE: begin
								pause_q <= 1'b1;
								st_q    <= S_DONE;
							end
							CMD_RESUME: begin
								pause_q <= 1'b0;
								st_q    <= S_DONE;
							end
							CMD_STOP: begin
								active_q <= '0;
								run_q    <= 1'b0;
								st_q     <= S_DONE;
							end
							CMD_SKIP: begin
								dwell_q <= '0;
								st_q    <= S_DONE;
							end
							default: begin
								pos_q <= '0;
								st_q  <= S_DONE;
							end
						endcase
					end
				end
				S_SCAN: begin
					if (int'(scan_q) >= WAYPOINTS) begin
						found_q <= '0;
						if (org_q) begin
							run_q <= 1'b0;
							st_q  <= S_DONE;
						end else begin
							st_q <= S_SRD;
						end
					end else if (en_q[scan_q[WP_AW-1:0]]) begin
						found_q <= scan_q[WP_AW-1:0];
						if (org_q) begin
							act_q    <= scan_q[WP_AW-1:0];
							active_q <= scan_q[WP_AW-1:0];
							st_q     <= S_ACT_RD0;
						end else begin
							st_q <= S_SRD;
						end
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				S_SRD: st_q <= S_SWR;
				S_SWR: begin
					en_q[0]  <= 1'b1;
					run_q    <= 1'b1;
					pause_q  <= 1'b0;
					act_q    <= '0;
					active_q <= '0;
					st_q     <= S_ACT_RD0;
				end
				S_ACT_RD0: st_q <= S_ACT_RD1;
				S_ACT_RD1: begin
					act_ent_q <= ent;
					st_q      <= S_ACT_CALC;
				end
				S_ACT_CALC: begin
					dwell_q <= act_ent_q.dwell;
					if ({18'd0, af} > ad) begin
						if (ad == '0) begin
							inc_q  <= {1'b0, af};
							rate_q <= act_ent_q.rate;
							st_q   <= (!org_q || act_ent_q.dwell != 0) ? S_DONE : S_STEP_RD;
						end else begin
							num_q <= af;
							den_q <= ad[14:0];
							rem_q <= '0;
							cnt_q <= '0;
							st_q  <= S_DIV;
						end
					end else begin
						inc_q <= 16'd1;
						st_q  <= (!org_q || act_ent_q.dwell != 0) ? S_DONE : S_STEP_RD;
					end
				end
				S_DIV: begin
					rem_q <= qbit ? 16'(trial - {1'b0, den_q}) : trial;
					num_q <= {num_q[13:0], qbit};
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == 4'd14) begin
						inc_q <= 16'({num_q[13:0], qbit}) + 16'd1;
						st_q  <= (!org_q || dwell_q != 0) ? S_DONE : S_STEP_RD;
					end
				end
				S_STEP_RD: begin
					org_q <= 1'b1;
					st_q  <= S_STEP_CHK;
				end
				S_STEP_CHK: begin
					if (d33 != '0) begin
						pulse_q <= 1'b1;
						dir_q   <= !d33[32];
						rate_q  <= ramp_rate;
						pos_q   <= d33[32] ? pos_q - 32'sd1 : pos_q + 32'sd1;
						st_q    <= S_DONE;
					end else begin
						scan_q <= {1'b0, active_q} + 1'b1;
						st_q   <= S_SCAN;
					end
				end
				S_DONE: begin
					if (out_free) begin
						out_data_q  <= '{step_pulse: pulse_q, step_direction: dir_q,
							step_rate: rate_q, current_position: pos_q, run_state: rs,
							active_waypoint: 4'(active_q)};
						st_q <= S_IDLE;
					end
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	a_out_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(st_q == S_DONE))
		else $error("result without completion");
	a_dir_needs_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.step_pulse |-> !out_data.step_direction)
		else $error("direction set without step");
	a_div_bound: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DIV |-> cnt_q <= 4'd14)
		else $error("divider overran");
	a_running_after_start: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_SWR |=> run_q && !pause_q)
		else $error("start did not arm sequence");

endmodule
